/* rtl/mrte_pkg.sv */
package mrte_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam logic [47:0] ADDR_ONES = '1;
    localparam logic [31:0] IFACE_WILDCARD = '1;
    localparam logic [31:0] METRIC_INFINITE = '1;

    typedef enum logic [3:0] {
        ACT_ADD_DEST    = 4'd0,
        ACT_ADD_ROOT    = 4'd1,
        ACT_DEL_DEST    = 4'd2,
        ACT_DEL_ROOT    = 4'd3,
        ACT_LOOK_DEST   = 4'd4,
        ACT_LOOK_DEST_A = 4'd5,
        ACT_LOOK_ROOT   = 4'd6,
        ACT_LOOK_ROOT_A = 4'd7,
        ACT_REPORT      = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // One queued command as passed from the front end to the back end.
    typedef struct packed {
        logic [3:0]  action;
        logic [47:0] key_addr;
        logic [47:0] next_hop;
        logic [31:0] iface;
        logic [31:0] path_metric;
        logic [31:0] expire;
        logic [31:0] seq_number;
        logic [31:0] now_time;
    } t_cmd;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_SCAN,
        BE_EXEC,
        BE_READ,
        BE_REPORT,
        BE_ROOT,
        BE_OUT
    } t_be_state;

endpackage

/* rtl/mrte_front.sv */
module mrte_front
    import mrte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_action,
    input  logic [47:0] i_key_addr,
    input  logic [47:0] i_next_hop,
    input  logic [31:0] i_iface,
    input  logic [31:0] i_path_metric,
    input  logic [31:0] i_life_span,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_now_time,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_take
);

    // Two-entry queue; the expiry sum is formed on entry.
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [32:0] sum;
    t_cmd       cmd_in;
    logic       push, pop;

    assign sum = {1'b0, i_now_time} + {1'b0, i_life_span};

    always_comb begin
        cmd_in.action      = i_action;
        cmd_in.key_addr    = i_key_addr;
        cmd_in.next_hop    = i_next_hop;
        cmd_in.iface       = i_iface;
        cmd_in.path_metric = i_path_metric;
        cmd_in.expire      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        cmd_in.seq_number  = i_seq_number;
        cmd_in.now_time    = i_now_time;
    end

    assign o_stall     = (r_cnt == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_take;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

/* rtl/mrte_back.sv */
module mrte_back
    import mrte_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_take,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [47:0] o_addr_out,
    output logic [31:0] o_iface_out,
    output logic [31:0] o_metric_out,
    output logic [31:0] o_seq_out,
    output logic signed [32:0] o_remaining,
    output logic        o_last
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [47:0] m_dest [ENTRIES];
    logic [47:0] m_nh   [ENTRIES];
    logic [31:0] m_ifc  [ENTRIES];
    logic [31:0] m_met  [ENTRIES];
    logic [31:0] m_seq  [ENTRIES];
    logic [31:0] m_exp  [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic [47:0] r_root_addr, r_root_nh;
    logic [31:0] r_root_ifc, r_root_met, r_root_seq, r_root_exp;

    t_be_state r_state, n_state;
    t_cmd      r_cmd;
    logic [CW-1:0] r_idx;
    logic          r_hit, r_free_ok, r_any;
    logic [IW-1:0] r_hit_idx, r_free_idx, r_rep_last;
    logic [47:0] r_rd_nh;
    logic [31:0] r_rd_ifc, r_rd_met, r_rd_seq, r_rd_exp;

    logic [1:0]  r_st;
    logic [47:0] r_addr;
    logic [31:0] r_ifc, r_met, r_seq;
    logic [32:0] r_rem;
    logic        r_last, r_ov;

    logic [IW-1:0] idx;
    logic          out_free;
    logic          scan_end;
    logic          rep_hit, root_hit, emit;

    assign idx      = r_idx[IW-1:0];
    assign out_free = !r_ov || !i_stall;
    assign scan_end = (r_idx == CW'(ENTRIES - 1));
    assign o_cmd_take = (r_state == BE_IDLE) && i_cmd_valid;

    // Slot and root matches against the failed peer of a report.
    assign rep_hit  = r_valid[idx] && (m_nh[idx] == r_cmd.key_addr);
    assign root_hit = (r_root_nh == r_cmd.key_addr);
    assign emit     = (r_state == BE_READ)
                   || (r_state == BE_REPORT && rep_hit)
                   || (r_state == BE_ROOT && (root_hit || !r_any));

    assign o_valid      = r_ov;
    assign o_status     = r_st;
    assign o_addr_out   = r_addr;
    assign o_iface_out  = r_ifc;
    assign o_metric_out = r_met;
    assign o_seq_out    = r_seq;
    assign o_remaining  = r_rem;
    assign o_last       = r_last;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BE_IDLE:   if (i_cmd_valid) n_state = BE_SCAN;
            BE_SCAN: begin
                if (scan_end) n_state = (r_cmd.action == ACT_REPORT) ? BE_REPORT : BE_EXEC;
            end
            BE_EXEC:   n_state = BE_READ;
            BE_READ:   if (out_free) n_state = BE_IDLE;
            BE_REPORT: if (out_free && scan_end) n_state = BE_ROOT;
            BE_ROOT:   if (out_free) n_state = BE_IDLE;
            default:   n_state = BE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        unique case (r_state)
            BE_SCAN: begin
                if (r_valid[idx] && m_dest[idx] == r_cmd.key_addr && !r_hit) begin
                    r_hit_idx <= idx;
                end
                if (!r_valid[idx] && !r_free_ok) begin
                    r_free_idx <= idx;
                end
                // The report pre-scan remembers the last matching slot.
                if (r_cmd.action == ACT_REPORT && rep_hit) begin
                    r_rep_last <= idx;
                end
            end
            BE_EXEC: begin
                r_rd_nh  <= m_nh[r_hit_idx];
                r_rd_ifc <= m_ifc[r_hit_idx];
                r_rd_met <= m_met[r_hit_idx];
                r_rd_seq <= m_seq[r_hit_idx];
                r_rd_exp <= m_exp[r_hit_idx];
                if (r_cmd.action == ACT_ADD_DEST && (r_hit || r_free_ok)) begin
                    m_dest[r_hit ? r_hit_idx : r_free_idx] <= r_cmd.key_addr;
                    m_nh[r_hit ? r_hit_idx : r_free_idx]   <= r_cmd.next_hop;
                    m_ifc[r_hit ? r_hit_idx : r_free_idx]  <= r_cmd.iface;
                    m_met[r_hit ? r_hit_idx : r_free_idx]  <= r_cmd.path_metric;
                    m_seq[r_hit ? r_hit_idx : r_free_idx]  <= r_cmd.seq_number;
                    m_exp[r_hit ? r_hit_idx : r_free_idx]  <= r_cmd.expire;
                end
            end
            BE_REPORT: begin
                if (out_free && rep_hit) begin
                    m_seq[idx] <= m_seq[idx] + 32'd1;
                end
            end
            default: ;
        endcase

        // Result register payload.
        if (out_free) begin
            r_ifc <= '0; r_met <= '0; r_rem <= '0; r_addr <= '0; r_seq <= '0;
            r_st  <= ST_MISS; r_last <= 1'b1;
            if (r_state == BE_READ) begin
                unique case (r_cmd.action)
                    ACT_ADD_DEST: r_st <= (r_hit || r_free_ok) ? ST_OK : ST_FULL;
                    ACT_ADD_ROOT: r_st <= ST_OK;
                    ACT_DEL_DEST: r_st <= r_hit ? ST_OK : ST_MISS;
                    ACT_DEL_ROOT:
                        r_st <= (r_root_addr == r_cmd.key_addr) ? ST_OK : ST_MISS;
                    ACT_LOOK_DEST, ACT_LOOK_DEST_A: begin
                        if (!r_hit || (r_cmd.action == ACT_LOOK_DEST
                                && r_rd_exp < r_cmd.now_time && r_rd_exp != 32'd0)) begin
                            r_addr <= ADDR_ONES; r_ifc <= IFACE_WILDCARD;
                            r_met  <= METRIC_INFINITE;
                        end else begin
                            r_addr <= r_rd_nh; r_ifc <= r_rd_ifc; r_met <= r_rd_met;
                            r_seq  <= r_rd_seq;
                            r_rem  <= {1'b0, r_rd_exp} - {1'b0, r_cmd.now_time};
                            r_st   <= (r_rd_nh == ADDR_ONES && r_rd_ifc == IFACE_WILDCARD
                                && r_rd_met == METRIC_INFINITE && r_rd_seq == 32'd0)
                                ? ST_MISS : ST_OK;
                        end
                    end
                    ACT_LOOK_ROOT, ACT_LOOK_ROOT_A: begin
                        r_addr <= r_root_nh; r_ifc <= r_root_ifc; r_met <= r_root_met;
                        r_seq  <= r_root_seq;
                        r_rem  <= {1'b0, r_root_exp} - {1'b0, r_cmd.now_time};
                        r_st   <= (r_root_nh == ADDR_ONES && r_root_ifc == IFACE_WILDCARD
                            && r_root_met == METRIC_INFINITE && r_root_seq == 32'd0)
                            ? ST_MISS : ST_OK;
                    end
                    default: r_st <= ST_MISS;
                endcase
            end else if (r_state == BE_REPORT) begin
                r_st   <= ST_OK;
                r_addr <= m_dest[idx];
                r_seq  <= m_seq[idx] + 32'd1;
                r_last <= (idx == r_rep_last) && !root_hit;
            end else if (r_state == BE_ROOT) begin
                if (root_hit) begin
                    r_st <= ST_OK; r_addr <= r_root_addr; r_seq <= r_root_seq;
                end
            end
        end

        if (!i_rst_n) begin
            r_state     <= BE_IDLE;
            r_valid     <= '0;
            r_ov        <= 1'b0;
            r_root_addr <= '0;
            r_root_nh   <= ADDR_ONES;
            r_root_ifc  <= IFACE_WILDCARD;
            r_root_met  <= METRIC_INFINITE;
            r_root_seq  <= '0;
            r_root_exp  <= '0;
        end else begin
            r_state <= n_state;
            if (out_free) r_ov <= emit;
            unique case (r_state)
                BE_IDLE: begin
                    r_idx <= '0; r_hit <= 1'b0; r_free_ok <= 1'b0; r_any <= 1'b0;
                end
                BE_SCAN: begin
                    if (r_cmd.action != ACT_REPORT) begin
                        if (r_valid[idx] && m_dest[idx] == r_cmd.key_addr) r_hit <= 1'b1;
                        if (!r_valid[idx]) r_free_ok <= 1'b1;
                    end else if (rep_hit) begin
                        r_any <= 1'b1;
                    end
                    if (!scan_end) r_idx <= r_idx + CW'(1);
                    else r_idx <= '0;
                end
                BE_EXEC: begin
                    unique case (r_cmd.action)
                        ACT_ADD_DEST: if (r_hit || r_free_ok)
                            r_valid[r_hit ? r_hit_idx : r_free_idx] <= 1'b1;
                        ACT_DEL_DEST: if (r_hit) r_valid[r_hit_idx] <= 1'b0;
                        ACT_ADD_ROOT: begin
                            r_root_addr <= r_cmd.key_addr; r_root_nh <= r_cmd.next_hop;
                            r_root_ifc  <= r_cmd.iface;    r_root_met <= r_cmd.path_metric;
                            r_root_seq  <= r_cmd.seq_number; r_root_exp <= r_cmd.expire;
                        end
                        ACT_DEL_ROOT, ACT_LOOK_ROOT: begin
                            if ((r_cmd.action == ACT_DEL_ROOT && r_root_addr == r_cmd.key_addr)
                                || (r_cmd.action == ACT_LOOK_ROOT
                                && r_root_exp < r_cmd.now_time)) begin
                                r_root_nh <= ADDR_ONES; r_root_ifc <= IFACE_WILDCARD;
                                r_root_met <= METRIC_INFINITE; r_root_seq <= '0;
                                r_root_exp <= r_cmd.now_time;
                            end
                        end
                        default: ;
                    endcase
                end
                BE_REPORT: begin
                    if (out_free && !scan_end) r_idx <= r_idx + CW'(1);
                end
                default: ;
            endcase
        end
    end

endmodule

/* rtl/mesh_route_table_expiry_unit.sv */
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   action, key, next hop, iface, metric, life, seq, now
// result    out        o_valid / i_stall   status, addr, iface, metric, seq, remaining, last
//
// A lookup, add or delete passes through the front-end queue, a linear scan of
// the slot table, an execute state and a result state before its result shows.
// A report first scans all slots to find its last match, then walks them again,
// one per cycle plus output stalls, and checks the root last. Reset is
// synchronous and active low and empties the table. A two-entry queue lets
// input transfers continue while the back end waits on a stalled result.
module mesh_route_table_expiry_unit
    import mrte_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_action,
    input  logic [47:0] i_key_addr,
    input  logic [47:0] i_next_hop,
    input  logic [31:0] i_iface,
    input  logic [31:0] i_path_metric,
    input  logic [31:0] i_life_span,
    input  logic [31:0] i_seq_number,
    input  logic [31:0] i_now_time,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [47:0] o_addr_out,
    output logic [31:0] o_iface_out,
    output logic [31:0] o_metric_out,
    output logic [31:0] o_seq_out,
    output logic signed [32:0] o_remaining,
    output logic        o_last
);

    t_cmd cmd;
    logic cmd_valid, cmd_take;

    mrte_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_action, .i_key_addr, .i_next_hop,
        .i_iface, .i_path_metric, .i_life_span, .i_seq_number, .i_now_time,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    mrte_back #(.ENTRIES(ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_take(cmd_take),
        .o_valid, .i_stall, .o_status, .o_addr_out, .o_iface_out, .o_metric_out,
        .o_seq_out, .o_remaining, .o_last
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for the mesh route table with per-route expiry.
// A scoreboard-style predictor mirrors the slot table and the root route,
// computes the results of every accepted input transfer, and the result
// monitor compares each output transfer field by field against the oldest
// prediction. Directed tests cover the corner cases; random tests then mix
// adds, deletes, lookups and unreachable reports over a small address pool
// so that hits, expiry and a full table all occur often.
module tb_top;
    import mrte_pkg::*;

    localparam int NSLOT = ENTRIES_DEF;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] addr;
        logic [31:0] iface;
        logic [31:0] metric;
        logic [31:0] seq;
        logic [32:0] remaining;
        logic        last;
    } t_route_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [3:0]  i_action = '0;
    logic [47:0] i_key_addr = '0;
    logic [47:0] i_next_hop = '0;
    logic [31:0] i_iface = '0;
    logic [31:0] i_path_metric = '0;
    logic [31:0] i_life_span = '0;
    logic [31:0] i_seq_number = '0;
    logic [31:0] i_now_time = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [47:0] o_addr_out;
    logic [31:0] o_iface_out;
    logic [31:0] o_metric_out;
    logic [31:0] o_seq_out;
    logic signed [32:0] o_remaining;
    logic        o_last;

    mesh_route_table_expiry_unit u_top (.*);

    // Shadow copy of the table state.
    logic        tbl_valid [NSLOT];
    logic [47:0] tbl_dest [NSLOT];
    logic [47:0] tbl_hop [NSLOT];
    logic [31:0] tbl_iface [NSLOT];
    logic [31:0] tbl_metric [NSLOT];
    logic [31:0] tbl_seq [NSLOT];
    logic [31:0] tbl_expire [NSLOT];
    logic [47:0] rt_addr;
    logic [47:0] rt_hop;
    logic [31:0] rt_iface;
    logic [31:0] rt_metric;
    logic [31:0] rt_seq;
    logic [31:0] rt_expire;

    t_route_result expected_results[$];
    int          mismatches = 0;
    logic [31:0] clock_us = 32'd0;
    bit          quiet_phase = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb_top failed");
        $finish;
    end

    function automatic void queue_result(t_route_result r);
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [31:0] expiry_time(logic [31:0] now, logic [31:0] life);
        logic [32:0] sum;
        sum = {1'b0, now} + {1'b0, life};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic t_route_result plain_result(t_status st);
        t_route_result r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int find_route(logic [47:0] key);
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_valid[i] && tbl_dest[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic void clear_root(logic [31:0] now);
        rt_hop = ADDR_ONES;
        rt_iface = IFACE_WILDCARD;
        rt_metric = METRIC_INFINITE;
        rt_seq = '0;
        rt_expire = now;
    endfunction

    function automatic void push_route(logic [47:0] hop, logic [31:0] ifc,
                                       logic [31:0] met, logic [31:0] sq,
                                       logic [31:0] exp, logic [31:0] now);
        t_route_result r;
        r.addr = hop;
        r.iface = ifc;
        r.metric = met;
        r.seq = sq;
        r.remaining = {1'b0, exp} - {1'b0, now};
        r.last = 1'b1;
        // All-ones hop, interface and metric with sequence zero mark a dead route.
        r.status = (hop == ADDR_ONES && ifc == IFACE_WILDCARD && met == METRIC_INFINITE
                    && sq == 0) ? ST_MISS : ST_OK;
        queue_result(r);
    endfunction

    // Applies one accepted command to the shadow state and queues its results.
    function automatic void predict_table_action(logic [3:0] act, logic [47:0] key,
            logic [47:0] hop, logic [31:0] ifc, logic [31:0] met, logic [31:0] life,
            logic [31:0] sq, logic [31:0] now);
        int s;
        int hits;
        t_route_result r;
        case (act)
            ACT_ADD_DEST: begin
                s = find_route(key);
                if (s < 0) begin
                    for (int i = NSLOT - 1; i >= 0; i--) if (!tbl_valid[i]) s = i;
                end
                if (s < 0) begin
                    queue_result(plain_result(ST_FULL));
                end else begin
                    tbl_valid[s] = 1'b1;
                    tbl_dest[s] = key;
                    tbl_hop[s] = hop;
                    tbl_iface[s] = ifc;
                    tbl_metric[s] = met;
                    tbl_seq[s] = sq;
                    tbl_expire[s] = expiry_time(now, life);
                    queue_result(plain_result(ST_OK));
                end
            end
            ACT_ADD_ROOT: begin
                rt_addr = key;
                rt_hop = hop;
                rt_iface = ifc;
                rt_metric = met;
                rt_seq = sq;
                rt_expire = expiry_time(now, life);
                queue_result(plain_result(ST_OK));
            end
            ACT_DEL_DEST: begin
                s = find_route(key);
                if (s >= 0) tbl_valid[s] = 1'b0;
                queue_result(plain_result(s >= 0 ? ST_OK : ST_MISS));
            end
            ACT_DEL_ROOT: begin
                if (rt_addr == key) clear_root(now);
                queue_result(plain_result(rt_addr == key ? ST_OK : ST_MISS));
            end
            ACT_LOOK_DEST, ACT_LOOK_DEST_A: begin
                s = find_route(key);
                if (s < 0 || (act == ACT_LOOK_DEST && tbl_expire[s] < now
                              && tbl_expire[s] != 0)) begin
                    r = plain_result(ST_MISS);
                    r.addr = ADDR_ONES;
                    r.iface = IFACE_WILDCARD;
                    r.metric = METRIC_INFINITE;
                    queue_result(r);
                end else begin
                    push_route(tbl_hop[s], tbl_iface[s], tbl_metric[s], tbl_seq[s],
                               tbl_expire[s], now);
                end
            end
            ACT_LOOK_ROOT, ACT_LOOK_ROOT_A: begin
                if (act == ACT_LOOK_ROOT && rt_expire < now) clear_root(now);
                push_route(rt_hop, rt_iface, rt_metric, rt_seq, rt_expire, now);
            end
            ACT_REPORT: begin
                hits = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_valid[i] && tbl_hop[i] == key) begin
                        tbl_seq[i] = tbl_seq[i] + 1;
                        r = '0;
                        r.addr = tbl_dest[i];
                        r.seq = tbl_seq[i];
                        queue_result(r);
                        hits++;
                    end
                end
                if (rt_hop == key) begin
                    r = '0;
                    r.addr = rt_addr;
                    r.seq = rt_seq;
                    queue_result(r);
                    hits++;
                end
                if (hits == 0) queue_result(plain_result(ST_MISS));
                else expected_results[$].last = 1'b1;
            end
            default: queue_result(plain_result(ST_MISS));
        endcase
    endfunction

    // Sends one command, with a random idle gap before it, and predicts it.
    // Valid stays high after the transfer until the next gap or drain.
    task automatic send_command(t_action act, logic [47:0] key, logic [47:0] hop,
                                logic [31:0] ifc, logic [31:0] met,
                                logic [31:0] life, logic [31:0] sq);
        while (!quiet_phase && $urandom_range(99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_key_addr <= key;
        i_next_hop <= hop;
        i_iface <= ifc;
        i_path_metric <= met;
        i_life_span <= life;
        i_seq_number <= sq;
        i_now_time <= clock_us;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_table_action(act, key, hop, ifc, met, life, sq, clock_us);
    endtask

    // Raw action code variant, used for codes outside the enum.
    task automatic send_raw_code(logic [3:0] code);
        i_valid <= 1'b1;
        i_action <= code;
        i_key_addr <= 48'({$urandom, $urandom});
        i_now_time <= clock_us;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_table_action(code, i_key_addr, i_next_hop, i_iface, i_path_metric,
                             i_life_span, i_seq_number, clock_us);
    endtask

    // Result stall generator.
    always @(posedge i_clk) begin
        i_stall <= !quiet_phase && ($urandom_range(99) < 14);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_route_result got;
        t_route_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_addr_out, o_iface_out, o_metric_out, o_seq_out,
                   o_remaining, o_last};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer %h", got);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of all fields, every action, the dead-route pattern and expiry.
    task automatic test_directed();
        send_command(ACT_LOOK_ROOT_A, '0, '0, '0, '0, '0, '0);
        send_command(ACT_LOOK_DEST, 48'h1, '0, '0, '0, '0, '0);
        send_command(ACT_ADD_DEST, ADDR_ONES, ADDR_ONES, '1, '1, '1, '1);
        send_command(ACT_ADD_DEST, '0, '0, '0, '0, '0, '0);
        send_command(ACT_LOOK_DEST, ADDR_ONES, '0, '0, '0, '0, '0);
        send_command(ACT_LOOK_DEST, '0, '0, '0, '0, '0, '0);
        send_command(ACT_ADD_DEST, 48'h5, ADDR_ONES, '1, '1, 32'd10, '0);
        send_command(ACT_LOOK_DEST_A, 48'h5, '0, '0, '0, '0, '0);
        clock_us = 32'd100;
        send_command(ACT_LOOK_DEST, 48'h5, '0, '0, '0, '0, '0);
        send_command(ACT_LOOK_DEST_A, 48'h5, '0, '0, '0, '0, '0);
        send_command(ACT_ADD_ROOT, 48'hAA, 48'h77, 32'd3, 32'd9, 32'd5, 32'd4);
        send_command(ACT_ADD_DEST, 48'h6, 48'h77, '0, '0, '0, '1);
        send_command(ACT_REPORT, 48'h77, '0, '0, '0, '0, '0);
        send_command(ACT_REPORT, 48'h1234, '0, '0, '0, '0, '0);
        send_command(ACT_LOOK_ROOT_A, '0, '0, '0, '0, '0, '0);
        clock_us = 32'd200;
        send_command(ACT_LOOK_ROOT, '0, '0, '0, '0, '0, '0);
        send_command(ACT_DEL_ROOT, 48'hBB, '0, '0, '0, '0, '0);
        send_command(ACT_DEL_ROOT, 48'hAA, '0, '0, '0, '0, '0);
        send_command(ACT_DEL_DEST, 48'h6, '0, '0, '0, '0, '0);
        send_command(ACT_DEL_DEST, 48'h6, '0, '0, '0, '0, '0);
        send_raw_code(4'd9);
        send_raw_code(4'd15);
        drain_results();
    endtask

    // Fill the table past its capacity, report its shared next hop, then empty it again.
    task automatic test_table_full();
        for (int i = 0; i < NSLOT + 2; i++)
            send_command(ACT_ADD_DEST, 48'h100 + i, 48'h33, $urandom, $urandom,
                         $urandom_range(1000), $urandom);
        send_command(ACT_REPORT, 48'h33, '0, '0, '0, '0, '0);
        for (int i = 0; i < NSLOT + 2; i++)
            send_command(ACT_DEL_DEST, 48'h100 + i, '0, '0, '0, '0, '0);
        drain_results();
    endtask

    function automatic logic [47:0] pool_addr();
        return ($urandom_range(9) == 0) ? 48'({$urandom, $urandom})
                                        : 48'h200 + $urandom_range(19);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Random mix over a small address pool with slowly advancing time.
    task automatic test_random_mix(int count);
        logic [3:0] code;
        for (int n = 0; n < count; n++) begin
            quiet_phase = (n >= count / 2) && (n < count / 2 + 30);
            if ($urandom_range(3) == 0) clock_us = clock_us + $urandom_range(50);
            if ($urandom_range(60) == 0) clock_us = clock_us + $urandom;
            code = $urandom_range(100) < 3 ? 4'(9 + $urandom_range(6))
                                           : 4'($urandom_range(8));
            if (code > ACT_REPORT) begin
                send_raw_code(code);
            end else begin
                send_command(t_action'(code), pool_addr(),
                             $urandom_range(3) == 0 ? ADDR_ONES : 48'h300 + $urandom_range(3),
                             rand_word(), rand_word(),
                             $urandom_range(4) == 0 ? rand_word() : $urandom_range(200),
                             rand_word());
            end
        end
        quiet_phase = 1'b0;
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
        rt_addr = '0;
        clear_root('0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random_mix(200);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mrte_pkg.sv
rtl/mrte_front.sv
rtl/mrte_back.sv
rtl/mesh_route_table_expiry_unit.sv
tb/tb_top.sv
